@@ rtl/fttd_pkg.sv @@
// shared types, register indexes and widths for the frame to tick dda stepper
package fttd_pkg;

  localparam int unsigned PosBitsDefault = 16;
  localparam int unsigned CntBits        = 16;
  localparam int unsigned ScaleBits      = 32;
  localparam int unsigned PosOutBits     = 16;
  localparam int unsigned CfgIdxBits     = 3;
  localparam int unsigned CfgDataBits    = 32;
  localparam int unsigned InDataBits     = 8;
  localparam int unsigned InUserBits     = 2;
  localparam int unsigned OutDataBits    = 40;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FRAME_COUNT      = 3'd0,
    CFG_TICK_COUNT       = 3'd1,
    CFG_TICKS_PER_FRAME  = 3'd2,
    CFG_TPF_SCALED       = 3'd3,
    CFG_FULL_SCALE       = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CntBits-1:0]   frame_count;
    logic [CntBits-1:0]   tick_count;
    logic [CntBits-1:0]   ticks_per_frame;
    logic [ScaleBits-1:0] tpf_scaled;
    logic [ScaleBits-1:0] full_scale;
  } cfg_t;

endpackage

@@ rtl/fttd_cfg.sv @@
// configuration register file written through the plain write port
module fttd_cfg import fttd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [CfgIdxBits-1:0]  idx_i,
  input  logic [CfgDataBits-1:0] data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_FRAME_COUNT:     cfg_d.frame_count     = data_i[CntBits-1:0];
        CFG_TICK_COUNT:      cfg_d.tick_count      = data_i[CntBits-1:0];
        CFG_TICKS_PER_FRAME: cfg_d.ticks_per_frame = data_i[CntBits-1:0];
        CFG_TPF_SCALED:      cfg_d.tpf_scaled      = data_i[ScaleBits-1:0];
        CFG_FULL_SCALE:      cfg_d.full_scale      = data_i[ScaleBits-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count     <= CntBits'(1);
      cfg_q.tick_count      <= CntBits'(1);
      cfg_q.ticks_per_frame <= CntBits'(1);
      cfg_q.tpf_scaled      <= ScaleBits'(1);
      cfg_q.full_scale      <= ScaleBits'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/fttd_step.sv @@
// next-state logic for one command: step (frame move, coarse tick advance, correction, rounding), start or end
module fttd_step import fttd_pkg::*; #(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  cfg_t                 cfg_i,
  input  cmd_e                 cmd_i,
  input  logic                 fwd_i,
  input  logic                 wrap_i,
  input  logic [POS_BITS-1:0]  frame_now_i,
  input  logic [POS_BITS-1:0]  tick_now_i,
  input  logic [ScaleBits-1:0] frame_scaled_i,
  input  logic [ScaleBits-1:0] tick_scaled_i,
  output logic                 accepted_o,
  output logic [POS_BITS-1:0]  frame_now_o,
  output logic [POS_BITS-1:0]  tick_now_o,
  output logic [ScaleBits-1:0] frame_scaled_o,
  output logic [ScaleBits-1:0] tick_scaled_o
);

  localparam int unsigned CmpBits = (POS_BITS > CntBits) ? POS_BITS : CntBits;

  logic [ScaleBits-1:0] fc_s, tc_s, half_s;
  logic                 wrapped;
  logic [POS_BITS-1:0]  nf, nt;
  logic [ScaleBits-1:0] nfs, nts, tgt;

  assign fc_s   = ScaleBits'(cfg_i.frame_count);
  assign tc_s   = ScaleBits'(cfg_i.tick_count);
  assign half_s = fc_s >> 1;

  always_comb begin
    // frame move
    wrapped = 1'b0;
    if (fwd_i) begin
      if (CmpBits'(frame_now_i) == CmpBits'(cfg_i.frame_count)) begin
        wrapped = 1'b1;
        nf      = '0;
        nfs     = '0;
      end else begin
        nf  = frame_now_i + POS_BITS'(1);
        nfs = frame_scaled_i + tc_s;
      end
    end else begin
      if (frame_now_i == '0) begin
        wrapped = 1'b1;
        nf      = POS_BITS'(cfg_i.frame_count);
        nfs     = cfg_i.full_scale;
      end else begin
        nf  = frame_now_i - POS_BITS'(1);
        nfs = frame_scaled_i - tc_s;
      end
    end

    nt  = tick_now_i;
    nts = tick_scaled_i;
    tgt = '0;
    if (wrapped) begin
      if (fwd_i) begin
        nt  = '0;
        nts = '0;
      end else begin
        nt  = POS_BITS'(cfg_i.tick_count);
        nts = nfs;
      end
    end else begin
      // coarse advance and one correction only when ticks outnumber frames
      if (cfg_i.frame_count < cfg_i.tick_count) begin
        if (fwd_i) begin
          nt  = nt + POS_BITS'(cfg_i.ticks_per_frame);
          nts = nts + cfg_i.tpf_scaled;
          if (nts < nfs && (nfs - nts) >= fc_s) begin
            nt  = nt + POS_BITS'(1);
            nts = nts + fc_s;
          end
        end else begin
          nt  = nt - POS_BITS'(cfg_i.ticks_per_frame);
          nts = nts - cfg_i.tpf_scaled;
          if (nts > nfs && (nts - nfs) >= fc_s) begin
            nt  = nt - POS_BITS'(1);
            nts = nts - fc_s;
          end
        end
      end
      // round to nearest tick using half a frame count
      if (fwd_i) begin
        tgt = nts + fc_s;
        if (nfs >= tgt || (tgt - nfs) <= half_s) begin
          nt  = nt + POS_BITS'(1);
          nts = tgt;
        end
      end else if (nts != '0) begin
        tgt = nts - fc_s;
        if (nfs <= tgt || (nfs - tgt) <= half_s) begin
          nt  = nt - POS_BITS'(1);
          nts = tgt;
        end
      end
    end
  end

  always_comb begin
    accepted_o     = 1'b0;
    frame_now_o    = frame_now_i;
    tick_now_o     = tick_now_i;
    frame_scaled_o = frame_scaled_i;
    tick_scaled_o  = tick_scaled_i;
    case (cmd_i)
      CMD_STEP: begin
        // refused wrap leaves everything as it was
        if (!(wrapped && !wrap_i)) begin
          accepted_o     = 1'b1;
          frame_now_o    = nf;
          tick_now_o     = nt;
          frame_scaled_o = nfs;
          tick_scaled_o  = nts;
        end
      end
      CMD_START: begin
        accepted_o     = 1'b1;
        frame_now_o    = '0;
        tick_now_o     = '0;
        frame_scaled_o = '0;
        tick_scaled_o  = '0;
      end
      CMD_END: begin
        accepted_o     = 1'b1;
        frame_now_o    = POS_BITS'(cfg_i.frame_count);
        tick_now_o     = POS_BITS'(cfg_i.tick_count);
        frame_scaled_o = cfg_i.full_scale;
        tick_scaled_o  = cfg_i.full_scale;
      end
      default: accepted_o = 1'b0;
    endcase
  end

endmodule

@@ rtl/frame_to_tick_dda_stepper.sv @@
// One command is taken per clock cycle, back to back, as long as the held command can move on,
// and each gives one result beat: the command is held in an input register, and the position
// state and the result register are updated together when it moves on, so the next command
// already sees the new state. The cycle time is set by the combinational step datapath (one
// coarse add, one correction, one rounding add and compare on 32-bit scaled values). After
// writing the five registers, issue a force-to-start command before stepping. The user must
// write configuration only while no command is in flight; the block does not enforce it.
module frame_to_tick_dda_stepper import fttd_pkg::*; #(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,  // go_forward, wrap_allowed, zero pad
  input  logic [InUserBits-1:0]  s_axis_tuser,  // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata   // accepted, frame_pos, tick_pos, zero pad
);

  cfg_t cfg;

  logic in_valid_d, in_valid_q;
  cmd_e in_cmd_q;
  logic in_fwd_q, in_wrap_q;

  logic [POS_BITS-1:0]  frame_now_q, tick_now_q, frame_now_d, tick_now_d;
  logic [ScaleBits-1:0] frame_scaled_q, tick_scaled_q, frame_scaled_d, tick_scaled_d;
  logic                 step_acc;

  logic                  out_valid_d, out_valid_q;
  logic                  out_acc_q;
  logic [PosOutBits-1:0] out_frame_q, out_tick_q;

  logic s_beat, adv;

  fttd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  fttd_step #(.POS_BITS(POS_BITS)) u_step (
    .cfg_i          (cfg),
    .cmd_i          (in_cmd_q),
    .fwd_i          (in_fwd_q),
    .wrap_i         (in_wrap_q),
    .frame_now_i    (frame_now_q),
    .tick_now_i     (tick_now_q),
    .frame_scaled_i (frame_scaled_q),
    .tick_scaled_i  (tick_scaled_q),
    .accepted_o     (step_acc),
    .frame_now_o    (frame_now_d),
    .tick_now_o     (tick_now_d),
    .frame_scaled_o (frame_scaled_d),
    .tick_scaled_o  (tick_scaled_d)
  );

  // a held command moves on whenever the result register is free or being drained
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_beat) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      frame_now_q    <= '0;
      tick_now_q     <= '0;
      frame_scaled_q <= '0;
      tick_scaled_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        frame_now_q    <= frame_now_d;
        tick_now_q     <= tick_now_d;
        frame_scaled_q <= frame_scaled_d;
        tick_scaled_q  <= tick_scaled_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_fwd_q  <= s_axis_tdata[0];
      in_wrap_q <= s_axis_tdata[1];
    end
    if (adv) begin
      out_acc_q   <= step_acc;
      out_frame_q <= PosOutBits'(frame_now_d);
      out_tick_q  <= PosOutBits'(tick_now_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataBits - 2 * PosOutBits - 1)'(0), out_tick_q, out_frame_q,
                          out_acc_q};

`ifndef SYNTHESIS
  a_refused_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !step_acc) |=> (frame_now_q == $past(frame_now_q) &&
                            tick_scaled_q == $past(tick_scaled_q)))
    else $error("refused command changed the position state");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_frame_q == PosOutBits'(frame_now_q) && out_tick_q == PosOutBits'(tick_now_q)))
    else $error("result beat disagrees with the position state");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_cmd_q == CMD_START) |=> (frame_now_q == '0 && tick_now_q == '0 &&
                                        frame_scaled_q == '0 && tick_scaled_q == '0))
    else $error("force to start left state behind");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
